@@ rtl/krcg_pkg.sv @@
// Package of shared types, constants and helpers for the keyed result cache.
package krcg_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_STORE      = 2'd1,
    OP_INVALIDATE = 2'd2,
    OP_NEW_FRAME  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] func_addr;
    logic [31:0] arg_hash;
    logic [63:0] store_value;
    logic [63:0] unit_id;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] hit_value;
  } out_item_t;

  // One cache slot as it is held in the slot memory.
  typedef struct packed {
    logic [63:0] unit;
    logic [31:0] key;
    logic [31:0] func;
    logic [63:0] value;
    logic [31:0] gen;
  } slot_t;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] FUNC_MASK = 32'h0000_0FFF;

  localparam int          NUM_FUNCS = 7;
  localparam logic [31:0] ALLOWED_FUNCS [NUM_FUNCS] = '{
    32'h0060_EB60, 32'h0060_ED40, 32'h0060_FEC0, 32'h0060_EC60,
    32'h0060_EF40, 32'h0060_F9E0, 32'h0000_0000
  };

  // True when the address is one of the cacheable functions.
  function automatic logic func_allowed(input logic [31:0] f);
    logic ok;
    ok = 1'b0;
    for (int i = 0; i < NUM_FUNCS; i++) begin
      if (ALLOWED_FUNCS[i] == f) begin
        ok = 1'b1;
      end
    end
    return ok;
  endfunction

endpackage

@@ rtl/krcg_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module krcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/keyed_result_cache_with_generations.sv @@
// Top level of the keyed result cache: control, hashing and the slot memory.
//
// A direct-mapped result cache keyed by an FNV-1a hash of the low 12 bits of
// the function address and the argument hash. A command is taken when start
// is high and busy is low; every command gives exactly one result, shown on
// out_item for one cycle with out_strobe high, and the receiver cannot hold
// it off. A new-frame command, or a lookup or store to a function outside
// the cacheable set, is answered straight from the idle state. A store
// passes through S_HASH and S_ACCESS, a lookup through S_HASH, S_ACCESS
// and S_CHECK (two hash multiplies in series, then the slot memory access
// whose read data is registered). When ENTRIES is not a power of two the
// slot index is a remainder found by a multiply with the reciprocal of
// ENTRIES and one compare and subtract, which adds the S_MOD and S_FOLD
// states to lookups and stores. An invalidate-by-unit command walks the
// slot memory through its one read port. After reset a clearing pass
// writes every slot to zero, one a cycle, and busy stays high until that
// pass is done, before the first command is taken.
module keyed_result_cache_with_generations #(
  parameter int ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  krcg_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output krcg_pkg::out_item_t  out_item
);

  import krcg_pkg::*;

  localparam int              IDXW     = $clog2(ENTRIES);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);
  localparam logic [IDXW:0]   ENT_W    = (IDXW + 1)'(ENTRIES);
  localparam bit              IS_POW2  = (ENTRIES & (ENTRIES - 1)) == 0;
  // floor(2^32 / ENTRIES); the quotient it gives is low by at most one.
  localparam logic [31:0]     RECIP    = 32'((64'd1 << 32) / ENTRIES);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_HASH   = 8'b00000100,
    S_MOD    = 8'b00001000,
    S_FOLD   = 8'b00010000,
    S_ACCESS = 8'b00100000,
    S_CHECK  = 8'b01000000,
    S_WALK   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  // Captured command fields; payload, so no reset.
  op_t         op_r;
  logic [31:0] func_r;
  logic [31:0] arg_r;
  logic [63:0] value_r;
  logic [63:0] unit_r;

  logic [31:0] gen_r, gen_nxt;
  logic [31:0] h1_r, h1_nxt;
  logic [31:0] key_r, key_nxt;
  logic [IDXW-1:0] rem_r, rem_nxt;
  logic [IDXW:0]   quot_r, quot_nxt;
  logic [IDXW-1:0] addr_r, addr_nxt;
  logic        walk_done_r, walk_done_nxt;
  logic        pend_r, pend_nxt;
  logic [IDXW-1:0] pend_addr_r, pend_addr_nxt;

  logic        out_strobe_r, out_strobe_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic            ram_we;
  logic [IDXW-1:0] ram_waddr;
  slot_t           ram_wdata;
  logic [IDXW-1:0] ram_raddr;
  slot_t           ram_rdata;

  logic            accept;
  logic [IDXW-1:0] slot_idx;
  logic [63:0]     recip_prod;
  logic [IDXW:0]   fold_prod;
  logic [IDXW:0]   fold_rem;
  logic [31:0]     gen_inc;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // The slot index is the low key bits for a power-of-two table and the
  // computed remainder otherwise.
  assign slot_idx   = IS_POW2 ? key_r[IDXW-1:0] : rem_r;
  assign recip_prod = 64'(key_r) * 64'(RECIP);
  // The estimated remainder is below twice ENTRIES, so its low bits suffice.
  assign fold_prod  = quot_r * ENT_W;
  assign fold_rem   = key_r[IDXW:0] - fold_prod;
  assign gen_inc    = gen_r + 32'd1;

  always_comb begin
    state_nxt      = state_r;
    gen_nxt        = gen_r;
    h1_nxt         = h1_r;
    key_nxt        = key_r;
    rem_nxt        = rem_r;
    quot_nxt       = quot_r;
    addr_nxt       = addr_r;
    walk_done_nxt  = walk_done_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    ram_we         = 1'b0;
    ram_waddr      = slot_idx;
    ram_wdata      = '0;
    ram_raddr      = slot_idx;

    unique case (state_r)
      S_CLEAR: begin
        // Zero every slot in address order after reset.
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        if (addr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + IDXW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          // First hash round: basis xor low address bits, times the prime.
          h1_nxt = (FNV_BASIS ^ (in_item.func_addr & FUNC_MASK)) * FNV_PRIME;
          unique case (in_item.operation)
            OP_LOOKUP, OP_STORE: begin
              if (func_allowed(in_item.func_addr)) begin
                state_nxt = S_HASH;
              end else begin
                out_strobe_nxt = 1'b1;
              end
            end
            OP_INVALIDATE: begin
              state_nxt     = S_WALK;
              addr_nxt      = '0;
              walk_done_nxt = 1'b0;
            end
            default: begin
              // New frame: bump the generation, skipping zero on wrap.
              gen_nxt        = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      S_HASH: begin
        key_nxt = (h1_r ^ arg_r) * FNV_PRIME;
        state_nxt = IS_POW2 ? S_ACCESS : S_MOD;
      end

      S_MOD: begin
        // Quotient estimate from the reciprocal; it is exact or one short.
        quot_nxt  = recip_prod[32 +: IDXW + 1];
        state_nxt = S_FOLD;
      end

      S_FOLD: begin
        // One compare and subtract brings the estimate into range.
        if (fold_rem >= ENT_W) begin
          rem_nxt = IDXW'(fold_rem - ENT_W);
        end else begin
          rem_nxt = fold_rem[IDXW-1:0];
        end
        state_nxt = S_ACCESS;
      end

      S_ACCESS: begin
        if (op_r == OP_STORE) begin
          ram_we         = 1'b1;
          ram_wdata      = '{unit: unit_r, key: key_r, func: func_r,
                             value: value_r, gen: gen_r};
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        out_strobe_nxt = 1'b1;
        if (ram_rdata.key == key_r && ram_rdata.func == func_r &&
            ram_rdata.gen == gen_r) begin
          out_item_nxt.hit       = 1'b1;
          out_item_nxt.hit_value = ram_rdata.value;
        end
        state_nxt = S_IDLE;
      end

      S_WALK: begin
        // Read one slot a cycle; the slot read in the previous cycle comes
        // back now and is written with generation zero if its unit matches.
        ram_raddr = addr_r;
        if (!walk_done_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = addr_r;
          if (addr_r == LAST_IDX) begin
            walk_done_nxt = 1'b1;
          end else begin
            addr_nxt = addr_r + IDXW'(1);
          end
        end
        if (pend_r) begin
          ram_waddr     = pend_addr_r;
          ram_wdata     = ram_rdata;
          ram_wdata.gen = '0;
          ram_we        = (ram_rdata.unit == unit_r);
          if (pend_addr_r == LAST_IDX) begin
            out_strobe_nxt = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      gen_r        <= 32'd1;
      addr_r       <= '0;
      walk_done_r  <= 1'b0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      gen_r        <= gen_nxt;
      addr_r       <= addr_nxt;
      walk_done_r  <= walk_done_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_item.operation;
      func_r  <= in_item.func_addr;
      arg_r   <= in_item.arg_hash;
      value_r <= in_item.store_value;
      unit_r  <= in_item.unit_id;
    end
    h1_r        <= h1_nxt;
    key_r       <= key_nxt;
    rem_r       <= rem_nxt;
    quot_r      <= quot_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_item_r  <= out_item_nxt;
  end

  krcg_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

@@ verif/keyed_result_cache_with_generations_tb.sv @@
// Self-checking testbench for the keyed result cache with generation tags.
`timescale 1ns / 1ps

module keyed_result_cache_with_generations_tb;
  import krcg_pkg::*;

  // The block is built with its default slot count. The shadow cache below
  // uses the same size, so the slot is the key modulo SLOTS in both places.
  localparam int SLOTS = 256;

  // Short names for the cacheable function addresses. FUNC6 is address zero.
  localparam logic [31:0] FUNC0 = ALLOWED_FUNCS[0];
  localparam logic [31:0] FUNC1 = ALLOWED_FUNCS[1];
  localparam logic [31:0] FUNC2 = ALLOWED_FUNCS[2];
  localparam logic [31:0] FUNC3 = ALLOWED_FUNCS[3];
  localparam logic [31:0] FUNC4 = ALLOWED_FUNCS[4];
  localparam logic [31:0] FUNC5 = ALLOWED_FUNCS[5];
  localparam logic [31:0] FUNC6 = ALLOWED_FUNCS[6];
  localparam logic [63:0] ONES  = '1;

  localparam int DIR_ROWS   = 25;
  localparam int RAND_ITEMS = 1525;
  localparam int POOL_SIZE  = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;

  keyed_result_cache_with_generations #(
    .ENTRIES(SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the cache contents and of the current frame generation.
  logic [63:0] cache_unit  [SLOTS];
  logic [31:0] cache_key   [SLOTS];
  logic [31:0] cache_func  [SLOTS];
  logic [63:0] cache_value [SLOTS];
  logic [31:0] cache_gen   [SLOTS];
  logic [31:0] frame_gen;

  // Results owed by the block, oldest first.
  out_item_t awaited_results[$];
  int        mismatches = 0;
  bit        gaps_on = 1'b1;

  // Recently stored queries and a few unit ids, so that lookups find live
  // entries and invalidates find units to retire.
  logic [31:0] recent_func [POOL_SIZE];
  logic [31:0] recent_arg  [POOL_SIZE];
  logic [63:0] unit_pool   [4];

  // One row of the directed sequence. Where fixed is set, the expected
  // result is the one given in the row; otherwise the shadow cache decides.
  typedef struct packed {
    op_t         op;
    logic [31:0] func;
    logic [31:0] arg;
    logic [63:0] val;
    logic [63:0] unit;
    logic        fixed;
    logic        exp_hit;
    logic [63:0] exp_val;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // Right after reset every slot holds generation zero, so nothing hits.
    '{OP_LOOKUP,     FUNC0, 32'h0000_0000, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0},
    '{OP_LOOKUP,     FUNC6, 32'hFFFF_FFFF, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0},
    // A store followed at once by its lookup returns the stored pattern.
    '{OP_STORE,      FUNC0, 32'h1234_5678, ONES,  ONES,  1'b1, 1'b0, 64'h0},
    '{OP_LOOKUP,     FUNC0, 32'h1234_5678, 64'h0, 64'h0, 1'b1, 1'b1, ONES},
    // Addresses outside the cacheable set never hit and never write.
    '{OP_LOOKUP,     32'h0060_EB61, 32'h1234_5678, 64'h0, 64'h0,
      1'b1, 1'b0, 64'h0},
    '{OP_STORE,      32'hFFFF_FFFF, 32'h1234_5678, ONES, 64'h0,
      1'b1, 1'b0, 64'h0},
    '{OP_STORE,      FUNC6, 32'hFFFF_FFFF, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0},
    '{OP_LOOKUP,     FUNC6, 32'hFFFF_FFFF, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0},
    '{OP_STORE,      FUNC1, 32'h0000_0001, 64'h8000_0000_0000_0001, 64'h3,
      1'b1, 1'b0, 64'h0},
    '{OP_STORE,      FUNC2, 32'h8000_0000, 64'h0123_4567_89AB_CDEF, 64'h5,
      1'b1, 1'b0, 64'h0},
    '{OP_STORE,      FUNC3, 32'hDEAD_BEEF, 64'hFEDC_BA98_7654_3210, 64'h7,
      1'b1, 1'b0, 64'h0},
    '{OP_STORE,      FUNC4, 32'h5555_AAAA, 64'h5555_5555_5555_5555, 64'h0,
      1'b1, 1'b0, 64'h0},
    '{OP_STORE,      FUNC5, 32'hAAAA_5555, 64'hAAAA_AAAA_AAAA_AAAA, ONES,
      1'b1, 1'b0, 64'h0},
    '{OP_LOOKUP,     FUNC1, 32'h0000_0001, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0},
    '{OP_LOOKUP,     FUNC2, 32'h8000_0000, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0},
    '{OP_LOOKUP,     FUNC3, 32'hDEAD_BEEF, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0},
    '{OP_LOOKUP,     FUNC4, 32'h5555_AAAA, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0},
    '{OP_LOOKUP,     FUNC5, 32'hAAAA_5555, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0},
    // A new frame retires every entry written so far.
    '{OP_NEW_FRAME,  32'h0, 32'h0, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0},
    '{OP_LOOKUP,     FUNC0, 32'h1234_5678, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0},
    // An entry written in the new frame, then retired by its unit id.
    '{OP_STORE,      FUNC2, 32'h8000_0000, ONES, 64'h5, 1'b1, 1'b0, 64'h0},
    '{OP_INVALIDATE, 32'h0, 32'h0, 64'h0, 64'h5, 1'b1, 1'b0, 64'h0},
    '{OP_LOOKUP,     FUNC2, 32'h8000_0000, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0},
    // Unit zero also matches every slot that was never written.
    '{OP_INVALIDATE, 32'h0, 32'h0, 64'h0, 64'h0, 1'b1, 1'b0, 64'h0},
    '{OP_INVALIDATE, 32'h0, 32'h0, 64'h0, ONES, 1'b1, 1'b0, 64'h0}
  };

  function automatic logic cacheable(input logic [31:0] addr);
    logic found;
    found = 1'b0;
    for (int i = 0; i < NUM_FUNCS; i++) begin
      found |= (ALLOWED_FUNCS[i] == addr);
    end
    return found;
  endfunction

  // FNV-1a over two words: the low 12 address bits, then the argument hash.
  function automatic logic [31:0] query_key(input logic [31:0] addr,
                                            input logic [31:0] arg);
    logic [31:0] h;
    h = FNV_BASIS ^ (addr & FUNC_MASK);
    h = h * FNV_PRIME;
    h = h ^ arg;
    h = h * FNV_PRIME;
    return h;
  endfunction

  // Applies one command to the shadow cache and returns the result it gives.
  function automatic out_item_t cache_response(input in_item_t cmd);
    out_item_t   res;
    logic [31:0] key;
    int unsigned slot;
    res = '0;
    case (cmd.operation)
      OP_LOOKUP, OP_STORE: begin
        if (cacheable(cmd.func_addr)) begin
          key  = query_key(cmd.func_addr, cmd.arg_hash);
          slot = key % SLOTS;
          if (cmd.operation == OP_LOOKUP) begin
            // A hit needs the full key, the exact function and the live frame.
            if (cache_key[slot] == key && cache_func[slot] == cmd.func_addr &&
                cache_gen[slot] == frame_gen) begin
              res.hit       = 1'b1;
              res.hit_value = cache_value[slot];
            end
          end else begin
            cache_unit[slot]  = cmd.unit_id;
            cache_key[slot]   = key;
            cache_func[slot]  = cmd.func_addr;
            cache_value[slot] = cmd.store_value;
            cache_gen[slot]   = frame_gen;
          end
        end
      end
      OP_INVALIDATE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (cache_unit[i] == cmd.unit_id) begin
            cache_gen[i] = '0;
          end
        end
      end
      default: begin
        // The generation skips zero on wrap, since zero marks a dead slot.
        frame_gen = frame_gen + 32'd1;
        if (frame_gen == '0) begin
          frame_gen = 32'd1;
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_unit();
    if ($urandom_range(99) < 85) begin
      return unit_pool[$urandom_range(3)];
    end
    return rand64();
  endfunction

  // Most random commands are lookups and stores on a small set of live
  // queries; a share is noise with any address and any operation.
  function automatic in_item_t random_command();
    in_item_t    cmd;
    int unsigned pick;
    int unsigned p;
    pick            = $urandom_range(99);
    p               = $urandom_range(POOL_SIZE - 1);
    cmd.operation   = OP_LOOKUP;
    cmd.func_addr   = recent_func[p];
    cmd.arg_hash    = recent_arg[p];
    cmd.store_value = rand64();
    cmd.unit_id     = rand64();
    if (pick < 8) begin
      cmd.operation = op_t'($urandom_range(3));
      cmd.func_addr = $urandom;
      cmd.arg_hash  = $urandom;
    end else if (pick < 50) begin
      if ($urandom_range(99) < 25) begin
        cmd.func_addr = ALLOWED_FUNCS[$urandom_range(NUM_FUNCS - 1)];
        cmd.arg_hash  = $urandom;
      end
    end else if (pick < 88) begin
      cmd.operation = OP_STORE;
      cmd.unit_id   = pick_unit();
      if ($urandom_range(1) == 0) begin
        cmd.func_addr  = ALLOWED_FUNCS[$urandom_range(NUM_FUNCS - 1)];
        cmd.arg_hash   = $urandom;
        recent_func[p] = cmd.func_addr;
        recent_arg[p]  = cmd.arg_hash;
      end
    end else if (pick < 94) begin
      cmd.operation = OP_INVALIDATE;
      cmd.unit_id   = pick_unit();
    end else begin
      cmd.operation = OP_NEW_FRAME;
    end
    return cmd;
  endfunction

  // Offers one command and holds it until busy is seen low.
  // The transfer happens at the edge where start is high and busy is low;
  // the owed result is queued when busy is first seen low after an edge.
  task automatic issue_command(input in_item_t cmd, input logic fixed,
                               input out_item_t fixed_res);
    out_item_t res;
    if (gaps_on) begin
      while ($urandom_range(99) < 15) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_item <= cmd;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    res = cache_response(cmd);
    awaited_results.push_back(fixed ? fixed_res : res);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Every strobed result is taken at the edge that ends its cycle and is
  // compared with the oldest owed result.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing owed");
      end else begin
        want = awaited_results.pop_front();
        if (out_item.hit !== want.hit) begin
          report_mismatch($sformatf("hit %b, wanted %b", out_item.hit, want.hit));
        end
        if (out_item.hit_value !== want.hit_value) begin
          report_mismatch($sformatf("hit_value %h, wanted %h",
                                    out_item.hit_value, want.hit_value));
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t  cmd;
    out_item_t fixed_res;
    for (int i = 0; i < SLOTS; i++) begin
      cache_unit[i]  = '0;
      cache_key[i]   = '0;
      cache_func[i]  = '0;
      cache_value[i] = '0;
      cache_gen[i]   = '0;
    end
    frame_gen = 32'd1;
    for (int i = 0; i < POOL_SIZE; i++) begin
      recent_func[i] = ALLOWED_FUNCS[$urandom_range(NUM_FUNCS - 1)];
      recent_arg[i]  = $urandom;
    end
    unit_pool[0] = '0;
    unit_pool[1] = ONES;
    unit_pool[2] = rand64();
    unit_pool[3] = rand64();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sequence. The block is busy clearing its slots for a while
    // after reset; the first row is offered while that pass runs.
    foreach (dir_rows[r]) begin
      cmd.operation       = dir_rows[r].op;
      cmd.func_addr       = dir_rows[r].func;
      cmd.arg_hash        = dir_rows[r].arg;
      cmd.store_value     = dir_rows[r].val;
      cmd.unit_id         = dir_rows[r].unit;
      fixed_res.hit       = dir_rows[r].exp_hit;
      fixed_res.hit_value = dir_rows[r].exp_val;
      issue_command(cmd, dir_rows[r].fixed, fixed_res);
    end

    // Random sequence, with a long stretch of back-to-back commands.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      gaps_on = !(n >= 600 && n < 900);
      issue_command(random_command(), 1'b0, '0);
    end
    start <= 1'b0;

    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
    // Any stray result would come within one invalidate walk.
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Backstop against a hang: long enough even if every command were a full
  // invalidate walk.
  initial begin : watchdog
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
